### hdl/multi_channel_soft_timer_assert.svh
// Assertion macros for the soft timer bank
`ifndef MULTI_CHANNEL_SOFT_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define MCST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define MCST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCST_ASSERT(lbl, prop, msg)
`define MCST_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/mcst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcst_pkg;

  localparam int ID_W = 5;
  localparam int DATA_W = 32;
  localparam int REQ_W = 3;
  localparam int DEF_NUM_TIMERS = 16;
  localparam int MAX_IDS = 31;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_TICK = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd1;
  localparam logic [REQ_W-1:0] REQ_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_DONE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_RUN = 3'd5;

  // operation carried along the cell row
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_TICK      = 3'd1,
    OP_START     = 3'd2,
    OP_STOP      = 3'd3,
    OP_READ_DONE = 3'd4,
    OP_READ_RUN  = 3'd5
  } op_t;

  // token walking the row, one cell per cycle
  typedef struct packed {
    logic              act;
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] period;
    logic              reload;
    logic              ok;
    logic              flag;
  } tok_t;

endpackage
`default_nettype wire

### hdl/mcst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mcst_cell import mcst_pkg::*; #(
  parameter int CELL_ID = 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t up_tok,
  output tok_t      dn_tok
);

  localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_ID);

  logic              running;
  logic              done;
  logic              periodic;
  logic              armed;
  logic [DATA_W-1:0] elapsed;
  logic [DATA_W-1:0] target;

  logic              running_next;
  logic              done_next;
  logic              periodic_next;
  logic              armed_next;
  logic [DATA_W-1:0] elapsed_next;
  logic [DATA_W-1:0] target_next;
  logic [DATA_W-1:0] elapsed_inc;
  logic              flag_hit;
  logic              match;

  assign match = (up_tok.id == MY_ID);
  assign elapsed_inc = running ? elapsed + DATA_W'(1) : elapsed;

  // apply the passing operation to this channel
  always_comb begin
    running_next  = running;
    done_next     = done;
    periodic_next = periodic;
    armed_next    = armed;
    elapsed_next  = elapsed;
    target_next   = target;
    flag_hit      = 1'b0;
    if (up_tok.act) begin
      case (up_tok.op)
        OP_TICK: begin
          elapsed_next = elapsed_inc;
          if (armed && (elapsed_inc >= target)) begin
            done_next    = 1'b1;
            elapsed_next = '0;
            if (!periodic) begin
              running_next = 1'b0;
            end
          end
        end
        OP_START: begin
          if (match) begin
            running_next  = 1'b1;
            elapsed_next  = '0;
            done_next     = 1'b0;
            target_next   = up_tok.period;
            periodic_next = up_tok.reload;
            armed_next    = 1'b1;
          end
        end
        OP_STOP: begin
          if (match) begin
            running_next = 1'b0;
          end
        end
        OP_READ_DONE: begin
          if (match) begin
            flag_hit  = done;
            done_next = 1'b0;
          end
        end
        OP_READ_RUN: begin
          if (match) begin
            flag_hit = running;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hold channel control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      periodic <= 1'b0;
      armed    <= 1'b0;
    end else begin
      running  <= running_next;
      done     <= done_next;
      periodic <= periodic_next;
      armed    <= armed_next;
    end
  end

  // hold count and period
  always_ff @(posedge clk) begin
    elapsed <= elapsed_next;
    target  <= target_next;
  end

  // advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_tok.act <= 1'b0;
    end else begin
      dn_tok      <= up_tok;
      dn_tok.flag <= up_tok.flag | flag_hit;
    end
  end

endmodule
`default_nettype wire

### hdl/multi_channel_soft_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// Bank of software-style timer channels, ids 1..min(NUM_TIMERS, 31).
// Input channel (in_valid/in_ready) carries one request: tick, allocate,
// start, stop, read-and-clear complete or read started. Output channel
// (out_valid/out_ready) returns exactly one result per request: ok,
// assigned_id and flag.
// Each channel lives in one cell of a row. A request is decoded on
// transfer, then walks the row one cell per cycle; every cell applies it
// to its own channel and passes it on. After the last cell the result is
// loaded into the output register. One request is handled at a time, so
// a new request is taken only once the last result has left the row.
// A finished result waits in the output register while the next request
// is taken; if the receiver stalls longer, the following result parks in a
// holding register and in_ready stays low until the output frees up.
// Reset (rst, synchronous) frees all channels and clears every channel's complete flag.
`include "multi_channel_soft_timer_assert.svh"
module multi_channel_soft_timer import mcst_pkg::*; #(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [ID_W-1:0]   timer_id,
  input  wire logic [DATA_W-1:0] period,
  input  wire logic              reload,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   ok,
  output logic [ID_W-1:0]        assigned_id,
  output logic                   flag
);

  localparam int NUM_CELLS = (NUM_TIMERS < MAX_IDS) ? NUM_TIMERS : MAX_IDS;
  localparam logic [ID_W-1:0] ID_CAP = ID_W'(NUM_CELLS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ID_W-1:0]   used_count;
  logic [ID_W-1:0]   used_count_next;
  tok_t              dec_tok;
  tok_t              tok_chain [NUM_CELLS+1];
  logic [NUM_CELLS:0] act_vec;
  tok_t              tail_tok;
  logic              hold_ok;
  logic [ID_W-1:0]   hold_id;
  logic              hold_flag;
  logic              accept;
  logic              out_free;
  logic              load_tail;
  logic              load_hold;
  logic              bank_full;
  logic [ID_W-1:0]   new_id;
  logic [ID_W-1:0]   start_id;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign tail_tok  = tok_chain[NUM_CELLS];
  assign bank_full = (used_count >= ID_CAP);
  assign new_id    = used_count + ID_W'(1);
  assign start_id  = (timer_id == '0) ? (bank_full ? '0 : new_id) : timer_id;

  // decode the request into a token for the row
  always_comb begin
    used_count_next = used_count;
    dec_tok         = '0;
    dec_tok.act     = 1'b1;
    dec_tok.op      = OP_NONE;
    dec_tok.period  = period;
    dec_tok.reload  = reload;
    case (req_type)
      REQ_TICK: begin
        dec_tok.op = OP_TICK;
        dec_tok.ok = 1'b1;
      end
      REQ_ALLOC: begin
        if (!bank_full) begin
          used_count_next = new_id;
          dec_tok.ok      = 1'b1;
          dec_tok.id      = new_id;
        end
      end
      REQ_START: begin
        if (timer_id == '0) begin
          if (!bank_full) begin
            used_count_next = new_id;
            dec_tok.op      = OP_START;
            dec_tok.ok      = 1'b1;
            dec_tok.id      = start_id;
          end
        end else if (timer_id <= used_count) begin
          dec_tok.op = OP_START;
          dec_tok.ok = 1'b1;
          dec_tok.id = start_id;
        end
      end
      REQ_STOP, REQ_READ_DONE, REQ_READ_RUN: begin
        if ((timer_id != '0) && (timer_id <= used_count)) begin
          dec_tok.ok = 1'b1;
          dec_tok.id = timer_id;
          case (req_type)
            REQ_STOP:      dec_tok.op = OP_STOP;
            REQ_READ_DONE: dec_tok.op = OP_READ_DONE;
            default:       dec_tok.op = OP_READ_RUN;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // hold the allocation count
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (accept) begin
      used_count <= used_count_next;
    end
  end

  // launch the token into the row
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_chain[0].act <= 1'b0;
    end else if (accept) begin
      tok_chain[0] <= dec_tok;
    end else begin
      tok_chain[0].act <= 1'b0;
    end
  end

  // row of channel cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mcst_cell #(
      .CELL_ID(i + 1)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .up_tok(tok_chain[i]),
      .dn_tok(tok_chain[i+1])
    );
  end

  for (genvar j = 0; j <= NUM_CELLS; j++) begin : g_act
    assign act_vec[j] = tok_chain[j].act;
  end

  // sequence one request at a time
  always_comb begin
    state_next = state;
    load_tail  = 1'b0;
    load_hold  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (tail_tok.act) begin
          if (out_free) begin
            load_tail  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_hold  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // park a result the receiver is not ready for
  always_ff @(posedge clk) begin
    if ((state == S_WALK) && tail_tok.act && !out_free) begin
      hold_ok   <= tail_tok.ok;
      hold_id   <= tail_tok.id;
      hold_flag <= tail_tok.flag;
    end
  end

  // drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_tail || load_hold) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tail) begin
      ok          <= tail_tok.ok;
      assigned_id <= tail_tok.id;
      flag        <= tail_tok.flag;
    end else if (load_hold) begin
      ok          <= hold_ok;
      assigned_id <= hold_id;
      flag        <= hold_flag;
    end
  end

  `MCST_ASSERT(a_one_token, $onehot0(act_vec), "more than one request in the cell row")
  `MCST_ASSERT(a_idle_empty, (state == S_IDLE) |-> (act_vec == '0), "token in row while idle")
  `MCST_ASSERT(a_used_cap, used_count <= ID_CAP, "allocation count above capacity")
  `MCST_ASSERT(a_fail_clean, (out_valid && !ok) |-> ((assigned_id == '0) && !flag), "bad failure")

endmodule
`default_nettype wire
